### src/ptc_pkg.sv
// shared types and constants for the plane triangle clipper
// no dependencies
package ptc_pkg;

  // classification of one triangle against the plane
  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_ALL_IN,
    MODE_ONE_IN,
    MODE_TWO_IN
  } ptc_mode_t;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_NORMAL_X     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_NORMAL_Y     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_NORMAL_Z     = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_OFFSET = 2'd3;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QCW    = 3;
  localparam int QPW    = 2;

  typedef struct packed {
    logic [QCW-1:0] count;
    logic           empty;
  } ptc_qstat_t;

endpackage

### src/ptc_front.sv
// front part: plane distance of each vertex, side test, rotation
// depends on ptc_pkg; pushes words into ptc_queue
module ptc_front #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16,
  localparam int C  = COORD_BITS,
  localparam int DW = ((2*C > C+FRAC_BITS) ? 2*C : C+FRAC_BITS) + 3,
  localparam int EW = 9*C + 3*DW + 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [9*C-1:0]       in_vtx,
  input  logic [3*C-1:0]       nrm,
  input  logic [C-1:0]         offs,
  input  ptc_pkg::ptc_qstat_t  qstat,
  output logic                 q_push,
  output logic [EW-1:0]        q_ent
);

  logic [2*C-1:0] p_r [9];
  logic [DW-1:0]  rs_r;
  logic [9*C-1:0] vtx_r;
  logic           s1_v_r;
  logic           acc;

  logic [DW-1:0]  d [3];
  logic [2:0]     ins;
  logic [1:0]     cnt;
  logic [1:0]     odd;
  ptc_pkg::ptc_mode_t mode;
  logic [3*C-1:0] vr [3];
  logic [DW-1:0]  dr [3];

  assign in_stall = (qstat.count + ptc_pkg::QCW'(s1_v_r)) >= ptc_pkg::QCW'(ptc_pkg::QDEPTH);
  assign acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
    end
  end

  // one multiplier per product, registered
  always_ff @(posedge clk) begin
    if (acc) begin
      for (int v = 0; v < 3; v++) begin
        for (int k = 0; k < 3; k++) begin
          p_r[v*3+k] <= $signed(nrm[k*C +: C]) * $signed(in_vtx[(v*3+k)*C +: C]);
        end
      end
      rs_r  <= DW'($signed(offs)) << FRAC_BITS;
      vtx_r <= in_vtx;
    end
  end

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      d[v] = DW'($signed(p_r[v*3])) + DW'($signed(p_r[v*3+1]))
           + DW'($signed(p_r[v*3+2])) - rs_r;
      ins[v] = !d[v][DW-1];
    end
    cnt = 2'(ins[0]) + 2'(ins[1]) + 2'(ins[2]);
    odd = 2'd0;
    mode = ptc_pkg::MODE_NONE;
    if (ins == 3'b111) begin
      mode = ptc_pkg::MODE_ALL_IN;
    end else if (cnt == 2'd1) begin
      mode = ptc_pkg::MODE_ONE_IN;
      odd  = ins[1] ? 2'd1 : (ins[2] ? 2'd2 : 2'd0);
    end else if (cnt == 2'd2) begin
      mode = ptc_pkg::MODE_TWO_IN;
      odd  = !ins[1] ? 2'd1 : (!ins[2] ? 2'd2 : 2'd0);
    end
    // rotate so the odd vertex comes first, winding kept
    case (odd)
      2'd1: begin
        vr[0] = vtx_r[3*C +: 3*C]; vr[1] = vtx_r[6*C +: 3*C]; vr[2] = vtx_r[0 +: 3*C];
        dr[0] = d[1]; dr[1] = d[2]; dr[2] = d[0];
      end
      2'd2: begin
        vr[0] = vtx_r[6*C +: 3*C]; vr[1] = vtx_r[0 +: 3*C]; vr[2] = vtx_r[3*C +: 3*C];
        dr[0] = d[2]; dr[1] = d[0]; dr[2] = d[1];
      end
      default: begin
        vr[0] = vtx_r[0 +: 3*C]; vr[1] = vtx_r[3*C +: 3*C]; vr[2] = vtx_r[6*C +: 3*C];
        dr[0] = d[0]; dr[1] = d[1]; dr[2] = d[2];
      end
    endcase
  end

  assign q_push = s1_v_r && (mode != ptc_pkg::MODE_NONE);
  assign q_ent  = {mode, dr[0], dr[1], dr[2], vr[2], vr[1], vr[0]};

endmodule

### src/ptc_queue.sv
// short fifo between front and back parts
// depends on ptc_pkg
module ptc_queue #(
  parameter int EW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [EW-1:0]       wdata,
  input  logic                pop,
  output logic [EW-1:0]       rdata,
  output ptc_pkg::ptc_qstat_t qstat
);

  logic [EW-1:0]           mem_r [ptc_pkg::QDEPTH];
  logic [ptc_pkg::QPW-1:0] wp_r, rp_r;
  logic [ptc_pkg::QCW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + ptc_pkg::QCW'(push) - ptc_pkg::QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  assign rdata       = mem_r[rp_r];
  assign qstat.count = cnt_r;
  assign qstat.empty = (cnt_r == '0);

endmodule

### src/ptc_back.sv
// back part: pipelined crossing divide, interpolation, piece emitter
// depends on ptc_pkg; pops words from ptc_queue
module ptc_back #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16,
  localparam int C   = COORD_BITS,
  localparam int F   = FRAC_BITS,
  localparam int DW  = ((2*C > C+F) ? 2*C : C+F) + 3,
  localparam int EW  = 9*C + 3*DW + 2,
  localparam int RW  = DW + 2,
  localparam int L   = F + 2,
  localparam int PLW = 9*C + 2,
  localparam int PRW = C + F + 3,
  localparam int SW  = C + 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ptc_pkg::ptc_qstat_t qstat,
  input  logic [EW-1:0]       q_ent,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [9*C-1:0]      out_tri,
  output logic                out_last
);

  logic           adv;
  logic [L-1:0]   v_r;
  logic [RW-1:0]  remb_r [L], remc_r [L], denb_r [L], denc_r [L];
  logic [F:0]     qb_r [L], qc_r [L];
  logic [PLW-1:0] pl_r [L];

  logic [RW-1:0]  remb_nxt [L], remc_nxt [L];
  logic [F:0]     qb_nxt [L], qc_nxt [L];
  logic [RW-1:0]  rb2 [L], rc2 [L];
  logic           geb [L], gec [L];

  logic [RW-1:0]  da0, db0, dc0, ra0, denb0, denc0;

  logic           m_v_r;
  logic [PRW-1:0] m_prod_r [6];
  logic [PLW-1:0] m_pl_r;
  logic [F:0]     tb, tc;
  logic [3*C-1:0] la, lb, lc;
  logic [C:0]     diff [6];

  logic           hold_v_r, piece_r;
  logic [3*C-1:0] hab_r, hac_r;
  logic [PLW-1:0] h_pl_r;
  logic [3*C-1:0] xs [2];
  logic [PRW-1:0] sh [6];
  logic [SW-1:0]  sm [6];

  logic           out_load, hold_last;
  logic [9*C-1:0] tri_sel;
  ptc_pkg::ptc_mode_t hmode;
  logic [3*C-1:0] ha, hb, hc;
  logic [9*C-1:0] out_tri_r;
  logic           out_valid_r, out_last_r;

  // stage 0 inputs: absolute distances and denominators
  always_comb begin
    da0   = RW'($signed(q_ent[9*C + 2*DW +: DW]));
    db0   = RW'($signed(q_ent[9*C + DW +: DW]));
    dc0   = RW'($signed(q_ent[9*C +: DW]));
    ra0   = da0[RW-1] ? -da0 : da0;
    denb0 = db0 - da0;
    denc0 = dc0 - da0;
    if (denb0[RW-1]) denb0 = -denb0;
    if (denc0[RW-1]) denc0 = -denc0;
  end

  // one restoring step per stage, one quotient bit each
  always_comb begin
    for (int j = 0; j < L; j++) begin
      geb[j] = 1'b0; gec[j] = 1'b0;
      rb2[j] = '0; rc2[j] = '0;
      remb_nxt[j] = '0; remc_nxt[j] = '0;
      qb_nxt[j] = '0; qc_nxt[j] = '0;
    end
    for (int j = 1; j < L; j++) begin
      geb[j] = remb_r[j-1] >= denb_r[j-1];
      gec[j] = remc_r[j-1] >= denc_r[j-1];
      rb2[j] = geb[j] ? remb_r[j-1] - denb_r[j-1] : remb_r[j-1];
      rc2[j] = gec[j] ? remc_r[j-1] - denc_r[j-1] : remc_r[j-1];
      remb_nxt[j] = rb2[j] << 1;
      remc_nxt[j] = rc2[j] << 1;
      qb_nxt[j] = {qb_r[j-1][F-1:0], geb[j]};
      qc_nxt[j] = {qc_r[j-1][F-1:0], gec[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      m_v_r    <= 1'b0;
      hold_v_r <= 1'b0;
    end else if (adv) begin
      v_r      <= {v_r[L-2:0], !qstat.empty};
      m_v_r    <= v_r[L-1];
      hold_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      remb_r[0] <= ra0;
      remc_r[0] <= ra0;
      denb_r[0] <= denb0;
      denc_r[0] <= denc0;
      qb_r[0]   <= '0;
      qc_r[0]   <= '0;
      pl_r[0]   <= {q_ent[EW-1 -: 2], q_ent[9*C-1:0]};
      for (int j = 1; j < L; j++) begin
        remb_r[j] <= remb_nxt[j];
        remc_r[j] <= remc_nxt[j];
        denb_r[j] <= denb_r[j-1];
        denc_r[j] <= denc_r[j-1];
        qb_r[j]   <= qb_nxt[j];
        qc_r[j]   <= qc_nxt[j];
        pl_r[j]   <= pl_r[j-1];
      end
    end
  end

  // interpolation products
  always_comb begin
    tb = (denb_r[L-1] == '0) ? '0 : qb_r[L-1];
    tc = (denc_r[L-1] == '0) ? '0 : qc_r[L-1];
    la = pl_r[L-1][0 +: 3*C];
    lb = pl_r[L-1][3*C +: 3*C];
    lc = pl_r[L-1][6*C +: 3*C];
    for (int k = 0; k < 3; k++) begin
      diff[k]   = (C+1)'($signed(lb[k*C +: C])) - (C+1)'($signed(la[k*C +: C]));
      diff[k+3] = (C+1)'($signed(lc[k*C +: C])) - (C+1)'($signed(la[k*C +: C]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        m_prod_r[k]   <= $signed(diff[k])   * $signed({1'b0, tb});
        m_prod_r[k+3] <= $signed(diff[k+3]) * $signed({1'b0, tc});
      end
      m_pl_r <= pl_r[L-1];
    end
  end

  // floor shift, add start vertex, saturate
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      xs[k] = '0;
    end
    for (int k = 0; k < 6; k++) begin
      sh[k] = $signed(m_prod_r[k]) >>> F;
      sm[k] = sh[k][SW-1:0] + SW'($signed(m_pl_r[(k%3)*C +: C]));
    end
    for (int k = 0; k < 6; k++) begin
      if ((&sm[k][SW-1:C-1]) || !(|sm[k][SW-1:C-1])) begin
        xs[k/3][(k%3)*C +: C] = sm[k][C-1:0];
      end else begin
        xs[k/3][(k%3)*C +: C] = {sm[k][SW-1], {(C-1){!sm[k][SW-1]}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hab_r  <= xs[0];
      hac_r  <= xs[1];
      h_pl_r <= m_pl_r;
    end
  end

  // piece emitter
  always_comb begin
    hmode = ptc_pkg::ptc_mode_t'(h_pl_r[PLW-1 -: 2]);
    ha = h_pl_r[0 +: 3*C];
    hb = h_pl_r[3*C +: 3*C];
    hc = h_pl_r[6*C +: 3*C];
    case (hmode)
      ptc_pkg::MODE_ONE_IN: tri_sel = {hac_r, hab_r, ha};
      ptc_pkg::MODE_TWO_IN: tri_sel = piece_r ? {hc, hab_r, hac_r} : {hc, hb, hab_r};
      default:              tri_sel = {hc, hb, ha};
    endcase
  end

  assign hold_last = (hmode != ptc_pkg::MODE_TWO_IN) || piece_r;
  assign out_load  = !out_valid_r || !out_stall;
  assign adv       = !hold_v_r || (out_load && hold_last);
  assign q_pop     = adv && !qstat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      piece_r     <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= hold_v_r;
      if (hold_v_r) piece_r <= !hold_last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && hold_v_r) begin
      out_tri_r  <= tri_sel;
      out_last_r <= hold_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_tri   = out_tri_r;
  assign out_last  = out_last_r;

endmodule

### src/plane_triangle_clipper_core.sv
// top level of the plane triangle clipper: config registers and wiring
// depends on ptc_pkg, ptc_front, ptc_queue, ptc_back
//
// channel | direction | handshake           | word
// in_     | input     | in_valid / in_stall  | three vertices, Q format coords
// out_    | output    | out_valid / out_stall| one triangle plus last-piece flag
// cfg_    | input     | cfg_valid / cfg_ready| register index and data
//
// an item yields one triangle, or two when it is split; while the piece emitter
// sends the first of two pieces, the back part holds the next item
// the delay from input accept to out_valid is set mostly by
// the one-bit-per-stage divider
// reset is synchronous, active low; the normal resets to +z and offset to 0
// output stall freezes the back pipeline once its hold stage is full; the front
// fills the 4-entry queue and stalls input when no slot is free for its word
module plane_triangle_clipper_core #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16,
  localparam int C  = COORD_BITS,
  localparam int DW = ((2*C > C+FRAC_BITS) ? 2*C : C+FRAC_BITS) + 3,
  localparam int EW = 9*C + 3*DW + 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [C-1:0]                      in_vertex_a_x,
  input  logic [C-1:0]                      in_vertex_a_y,
  input  logic [C-1:0]                      in_vertex_a_z,
  input  logic [C-1:0]                      in_vertex_b_x,
  input  logic [C-1:0]                      in_vertex_b_y,
  input  logic [C-1:0]                      in_vertex_b_z,
  input  logic [C-1:0]                      in_vertex_c_x,
  input  logic [C-1:0]                      in_vertex_c_y,
  input  logic [C-1:0]                      in_vertex_c_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [C-1:0]                      out_a_x,
  output logic [C-1:0]                      out_a_y,
  output logic [C-1:0]                      out_a_z,
  output logic [C-1:0]                      out_b_x,
  output logic [C-1:0]                      out_b_y,
  output logic [C-1:0]                      out_b_z,
  output logic [C-1:0]                      out_c_x,
  output logic [C-1:0]                      out_c_y,
  output logic [C-1:0]                      out_c_z,
  output logic                              out_last_piece,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ptc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [C-1:0]                      cfg_data
);

  // plane registers
  logic [C-1:0] nx_r, ny_r, nz_r, off_r;

  logic                q_push, q_pop;
  logic [EW-1:0]       q_wdata, q_rdata;
  ptc_pkg::ptc_qstat_t qstat;
  logic [9*C-1:0]      out_tri;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r  <= '0;
      ny_r  <= '0;
      nz_r  <= {{(C-1){1'b0}}, 1'b1} << FRAC_BITS;
      off_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ptc_pkg::REG_NORMAL_X:     nx_r  <= cfg_data;
        ptc_pkg::REG_NORMAL_Y:     ny_r  <= cfg_data;
        ptc_pkg::REG_NORMAL_Z:     nz_r  <= cfg_data;
        ptc_pkg::REG_PLANE_OFFSET: off_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: products, side test, rotation
  ptc_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_vtx   ({in_vertex_c_z, in_vertex_c_y, in_vertex_c_x,
                in_vertex_b_z, in_vertex_b_y, in_vertex_b_x,
                in_vertex_a_z, in_vertex_a_y, in_vertex_a_x}),
    .nrm      ({nz_r, ny_r, nx_r}),
    .offs     (off_r),
    .qstat    (qstat),
    .q_push   (q_push),
    .q_ent    (q_wdata)
  );

  // decoupling queue
  ptc_queue #(.EW(EW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .qstat (qstat)
  );

  // back: divide, interpolate, emit pieces
  ptc_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .q_ent     (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_tri   (out_tri),
    .out_last  (out_last_piece)
  );

  assign out_a_x = out_tri[0*C +: C];
  assign out_a_y = out_tri[1*C +: C];
  assign out_a_z = out_tri[2*C +: C];
  assign out_b_x = out_tri[3*C +: C];
  assign out_b_y = out_tri[4*C +: C];
  assign out_b_z = out_tri[5*C +: C];
  assign out_c_x = out_tri[6*C +: C];
  assign out_c_y = out_tri[7*C +: C];
  assign out_c_z = out_tri[8*C +: C];

`ifndef SYNTHESIS
  // queue occupancy stays within its depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= ptc_pkg::QCW'(ptc_pkg::QDEPTH))
    else $error("queue count beyond depth");

  // the second piece of a split triangle follows right after the first
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_piece |=> out_valid)
    else $error("second piece missing");

  // the queue is never popped while empty
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !qstat.empty)
    else $error("pop from empty queue");
`endif

endmodule

### dv/plane_triangle_clipper_core_tb.sv
// testbench for plane_triangle_clipper_core: random and directed triangles
// checked against a fixed-point clipping predictor; depends on ptc_pkg and the rtl
`timescale 1ns / 100ps

module plane_triangle_clipper_core_tb;

  localparam int C = 32;
  localparam int FB = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic [C-1:0] coord_t;
  typedef struct packed { coord_t x, y, z; } vtx_t;
  typedef struct packed { vtx_t a, b, c; } tri_t;
  typedef struct packed { tri_t t; logic last; } piece_t;
  typedef logic signed [127:0] wide_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, out_last_piece;
  logic cfg_valid, cfg_ready;
  logic [ptc_pkg::CFG_IDX_BITS-1:0] cfg_index;
  coord_t cfg_data;
  tri_t in_word;
  coord_t oax, oay, oaz, obx, oby, obz, ocx, ocy, ocz;

  // plane as the block should hold it
  coord_t pl_nx, pl_ny, pl_nz, pl_r;

  tri_t   tri_pending[$];
  piece_t clip_expected[$];
  int     mismatches;
  bit     calm;
  int     idle_left, stall_left, quiet_cycles;

  plane_triangle_clipper_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_vertex_a_x(in_word.a.x), .in_vertex_a_y(in_word.a.y), .in_vertex_a_z(in_word.a.z),
    .in_vertex_b_x(in_word.b.x), .in_vertex_b_y(in_word.b.y), .in_vertex_b_z(in_word.b.z),
    .in_vertex_c_x(in_word.c.x), .in_vertex_c_y(in_word.c.y), .in_vertex_c_z(in_word.c.z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_a_x(oax), .out_a_y(oay), .out_a_z(oaz),
    .out_b_x(obx), .out_b_y(oby), .out_b_z(obz),
    .out_c_x(ocx), .out_c_y(ocy), .out_c_z(ocz),
    .out_last_piece(out_last_piece),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic wide_t sx(coord_t v);
    wide_t w;
    w = $signed(v);
    return w;
  endfunction

  // signed distance at scale 2^(2*FB), exact
  function automatic wide_t vtx_dist(vtx_t p);
    return sx(pl_nx) * sx(p.x) + sx(pl_ny) * sx(p.y) + sx(pl_nz) * sx(p.z)
           - (sx(pl_r) <<< FB);
  endfunction

  // point where edge a-q meets the plane, floor rounding, saturated
  function automatic vtx_t edge_cut(vtx_t a, vtx_t q, wide_t da, wide_t dq);
    wide_t diff, prod, s, den, num;
    logic [127:0] t;
    coord_t ca[3], cq[3], o[3];
    vtx_t r;
    ca[0] = a.x; ca[1] = a.y; ca[2] = a.z;
    cq[0] = q.x; cq[1] = q.y; cq[2] = q.z;
    den = dq - da;
    if (den < 0) den = -den;
    num = (da < 0) ? -da : da;
    num = num <<< FB;
    t = (den == 0) ? 128'd0 : (128'(unsigned'(num)) / 128'(unsigned'(den)));
    t = {64'd0, t[63:0]};
    for (int i = 0; i < 3; i++) begin
      diff = sx(cq[i]) - sx(ca[i]);
      prod = (diff * $signed(t)) >>> FB;
      s = prod + sx(ca[i]);
      if (s > 128'sd2147483647) o[i] = 32'h7fffffff;
      else if (s < -128'sd2147483648) o[i] = 32'h80000000;
      else o[i] = s[C-1:0];
    end
    r.x = o[0]; r.y = o[1]; r.z = o[2];
    return r;
  endfunction

  // queue the triangles the block should emit for one accepted word
  task automatic predict_clip(tri_t w);
    vtx_t v[3], ab, ac;
    wide_t d[3];
    bit ins[3];
    int n_in, odd, ib, ic;
    piece_t p;
    v[0] = w.a; v[1] = w.b; v[2] = w.c;
    n_in = 0;
    odd = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = vtx_dist(v[i]);
      ins[i] = (d[i] >= 0);
      n_in += ins[i];
    end
    if (n_in == 3) begin
      p.t = w; p.last = 1'b1;
      clip_expected.push_back(p);
    end else if (n_in != 0) begin
      // odd vertex: the lone inside one, or the lone outside one
      for (int i = 0; i < 3; i++)
        if (ins[i] == (n_in == 1)) odd = i;
      ib = (odd + 1) % 3;
      ic = (odd + 2) % 3;
      ab = edge_cut(v[odd], v[ib], d[odd], d[ib]);
      ac = edge_cut(v[odd], v[ic], d[odd], d[ic]);
      if (n_in == 1) begin
        p.t.a = v[odd]; p.t.b = ab; p.t.c = ac; p.last = 1'b1;
        clip_expected.push_back(p);
      end else begin
        p.t.a = ab; p.t.b = v[ib]; p.t.c = v[ic]; p.last = 1'b0;
        clip_expected.push_back(p);
        p.t.a = ac; p.t.b = ab; p.t.c = v[ic]; p.last = 1'b1;
        clip_expected.push_back(p);
      end
    end
  endtask

  // driver: predicts on acceptance, then loads the next word or idles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid && !in_stall) predict_clip(in_word);
      if (!in_valid || !in_stall) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (tri_pending.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
          idle_left = $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else if (tri_pending.size() != 0) begin
          in_word <= tri_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stall bursts, compare each accepted triangle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        piece_t got, want;
        got.t.a = '{oax, oay, oaz};
        got.t.b = '{obx, oby, obz};
        got.t.c = '{ocx, ocy, ocz};
        got.last = out_last_piece;
        if (clip_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output triangle %h", got);
        end else begin
          want = clip_expected.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp a=%h b=%h c=%h last=%b / got a=%h b=%h c=%h last=%b",
                       want.t.a, want.t.b, want.t.c, want.last,
                       got.t.a, got.t.b, got.t.c, got.last);
          end
        end
      end
      if (calm) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic [ptc_pkg::CFG_IDX_BITS-1:0] idx, coord_t val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ptc_pkg::REG_NORMAL_X: pl_nx = val;
      ptc_pkg::REG_NORMAL_Y: pl_ny = val;
      ptc_pkg::REG_NORMAL_Z: pl_nz = val;
      default:               pl_r  = val;
    endcase
  endtask

  task automatic set_plane(coord_t nx, coord_t ny, coord_t nz, coord_t r);
    write_reg(ptc_pkg::REG_NORMAL_X, nx);
    write_reg(ptc_pkg::REG_NORMAL_Y, ny);
    write_reg(ptc_pkg::REG_NORMAL_Z, nz);
    write_reg(ptc_pkg::REG_PLANE_OFFSET, r);
  endtask

  // sender holds off until the block has drained
  task automatic wait_drained();
    wait (tri_pending.size() == 0 && !in_valid && clip_expected.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  // mostly small coords around the plane, sometimes full range
  function automatic coord_t rnd_coord(bit full);
    if (full) return $urandom;
    return coord_t'(int'($urandom_range(0, 32'h200000)) - 32'h100000);
  endfunction

  function automatic vtx_t rnd_vtx(bit full);
    vtx_t v;
    v.x = rnd_coord(full); v.y = rnd_coord(full); v.z = rnd_coord(full);
    return v;
  endfunction

  function automatic coord_t rnd_normal();
    return coord_t'(int'($urandom_range(0, 32'h40000)) - 32'h20000);
  endfunction

  task automatic push_random(int n);
    tri_t t;
    bit full;
    repeat (n) begin
      full = ($urandom_range(0, 7) == 0);
      t.a = rnd_vtx(full); t.b = rnd_vtx(full); t.c = rnd_vtx(full);
      tri_pending.push_back(t);
    end
  endtask

  function automatic vtx_t vz(int zq);
    vtx_t v;
    v.x = coord_t'($urandom_range(0, 32'h30000));
    v.y = coord_t'(-int'($urandom_range(0, 32'h30000)));
    v.z = coord_t'(zq);
    return v;
  endfunction

  task automatic push_tri(vtx_t a, vtx_t b, vtx_t c);
    tri_t t;
    t.a = a; t.b = b; t.c = c;
    tri_pending.push_back(t);
  endtask

  initial begin
    vtx_t hi, lo;
    rst_n = 1'b0;
    calm = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pl_nx = 0; pl_ny = 0; pl_nz = 32'h00010000; pl_r = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words against the reset plane z = 0
    push_tri(vz(32'h10000), vz(32'h20000), vz(32'h30000));      // all inside
    push_tri(vz(-32'h10000), vz(-32'h20000), vz(-32'h8000));    // all outside
    push_tri(vz(32'h10000), vz(-32'h10000), vz(-32'h20000));    // one inside, each rotation
    push_tri(vz(-32'h10000), vz(32'h10000), vz(-32'h20000));
    push_tri(vz(-32'h10000), vz(-32'h20000), vz(32'h10000));
    push_tri(vz(-32'h10000), vz(32'h10000), vz(32'h20000));     // two inside, each rotation
    push_tri(vz(32'h10000), vz(-32'h10000), vz(32'h20000));
    push_tri(vz(32'h10000), vz(32'h20000), vz(-32'h10000));
    push_tri(vz(0), vz(-32'h10000), vz(-32'h20000));            // vertex on the plane
    push_tri(vz(0), vz(0), vz(0));
    push_tri(vz(-1), vz(32'h7fffffff), vz(-32'h7fffffff));
    hi = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    lo = '{32'h80000000, 32'h80000000, 32'h80000000};
    push_tri(hi, lo, hi);
    push_tri(lo, hi, lo);
    push_tri(lo, lo, lo);
    push_tri(hi, hi, hi);
    push_tri('{32'h80000000, 32'h7fffffff, 32'h7fffffff}, lo,
             '{32'h7fffffff, 32'h80000000, 32'h00000001});
    wait_drained();

    // extreme normals and offsets
    set_plane(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    push_tri(hi, lo, hi); push_tri(lo, hi, lo);
    push_random(110);
    wait_drained();
    set_plane(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    push_tri(hi, lo, hi); push_tri(lo, hi, lo);
    push_random(110);
    wait_drained();

    // zero normal: everything in or everything out
    set_plane(0, 0, 0, 0);
    push_random(30);
    wait_drained();
    set_plane(0, 0, 0, 32'h00000001);
    push_random(30);
    wait_drained();

    // random planes through the small-coordinate cloud
    repeat (6) begin
      set_plane(rnd_normal(), rnd_normal(), rnd_normal(),
                coord_t'(int'($urandom_range(0, 32'h20000)) - 32'h10000));
      push_random(110);
      wait_drained();
    end

    // final stretch without idling on either side
    calm = 1'b1;
    set_plane(rnd_normal(), rnd_normal(), rnd_normal(), 0);
    push_random(100);
    wait_drained();

    if (mismatches == 0 && clip_expected.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
